>>> rtl/pendulum_trajectory_generator_macros.svh
// Assertion macros for the pendulum trajectory generator checker
`ifndef PENDULUM_TRAJECTORY_GENERATOR_MACROS_SVH
`define PENDULUM_TRAJECTORY_GENERATOR_MACROS_SVH

// same-cycle implication, clocked on clk_i, off during reset
`define PDT_ASSERT_NOW(label, a, c) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (a) |-> (c)) \
    else $error("pendulum trajectory generator check failed");

// next-cycle implication
`define PDT_ASSERT_NEXT(label, a, c) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (a) |=> (c)) \
    else $error("pendulum trajectory generator check failed");

`endif

>>> rtl/pdt_pkg.sv
// Shared types, constants and helper functions of the pendulum trajectory generator
package pdt_pkg;

  localparam int unsigned DefCordicStages = 16;
  localparam int unsigned DefPhaseBits    = 32;
  localparam int unsigned CordicW         = 33;

  localparam logic signed [CordicW-1:0] CordicGain = 33'sd652032874;
  localparam logic signed [31:0]        RadToBinang = 32'sd1367130551;

  localparam logic [2:0] RegLength = 3'd0;
  localparam logic [2:0] RegAmp    = 3'd1;
  localparam logic [2:0] RegOmega  = 3'd2;
  localparam logic [2:0] RegStep   = 3'd3;
  localparam logic [2:0] RegCount  = 3'd4;

  typedef struct packed {
    logic                      valid;
    logic [1:0]                quad;
    logic signed [CordicW-1:0] x;
    logic signed [CordicW-1:0] y;
    logic signed [CordicW-1:0] z;
  } cordic_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_PASS1,
    ST_MUL1,
    ST_MUL2,
    ST_PASS2,
    ST_MUL3,
    ST_MUL4,
    ST_DONE
  } state_e;

  function automatic logic signed [CordicW-1:0] atan_turn(input int unsigned i);
    logic signed [CordicW-1:0] r;
    case (i)
      0:       r = 33'sd536870912;
      1:       r = 33'sd316933406;
      2:       r = 33'sd167458907;
      3:       r = 33'sd85004756;
      4:       r = 33'sd42667331;
      5:       r = 33'sd21354465;
      6:       r = 33'sd10679838;
      7:       r = 33'sd5340245;
      8:       r = 33'sd2670163;
      9:       r = 33'sd1335087;
      10:      r = 33'sd667544;
      11:      r = 33'sd333772;
      12:      r = 33'sd166886;
      13:      r = 33'sd83443;
      14:      r = 33'sd41722;
      15:      r = 33'sd20861;
      16:      r = 33'sd10430;
      17:      r = 33'sd5215;
      18:      r = 33'sd2608;
      19:      r = 33'sd1304;
      20:      r = 33'sd652;
      21:      r = 33'sd326;
      22:      r = 33'sd163;
      23:      r = 33'sd81;
      default: r = '0;
    endcase
    return r;
  endfunction

  function automatic logic signed [63:0] round_shift(input logic signed [63:0] v,
                                                     input int unsigned s);
    logic signed [63:0] half;
    half = 64'sd1 <<< (s - 1);
    return (v + half) >>> s;
  endfunction

  function automatic logic signed [63:0] sat(input logic signed [63:0] v,
                                             input int unsigned w);
    logic signed [63:0] hi;
    logic signed [63:0] lo;
    hi = (64'sd1 <<< (w - 1)) - 64'sd1;
    lo = -hi - 64'sd1;
    return (v > hi) ? hi : ((v < lo) ? lo : v);
  endfunction

endpackage

>>> rtl/pdt_cordic_cell.sv
// One rotation cell of the CORDIC row
module pdt_cordic_cell import pdt_pkg::*; #(
  parameter int unsigned STAGE = 0
) (
  input  logic    clk_i,
  input  logic    rst_ni,
  input  cordic_t cell_i,
  output cordic_t cell_o
);

  localparam logic signed [CordicW-1:0] Atan = atan_turn(STAGE);

  logic                      valid_q;
  logic [1:0]                quad_q;
  logic signed [CordicW-1:0] x_q, y_q, z_q;
  logic signed [CordicW-1:0] x_d, y_d, z_d;
  logic signed [CordicW-1:0] dx, dy;

  always_comb begin
    dx = cell_i.y >>> STAGE;
    dy = cell_i.x >>> STAGE;
    if (!cell_i.z[CordicW-1]) begin
      x_d = cell_i.x - dx;
      y_d = cell_i.y + dy;
      z_d = cell_i.z - Atan;
    end else begin
      x_d = cell_i.x + dx;
      y_d = cell_i.y - dy;
      z_d = cell_i.z + Atan;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= cell_i.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    quad_q <= cell_i.quad;
    x_q    <= x_d;
    y_q    <= y_d;
    z_q    <= z_d;
  end

  assign cell_o = '{valid: valid_q, quad: quad_q, x: x_q, y: y_q, z: z_q};

endmodule

>>> rtl/pdt_cordic_chain.sv
// Row of CORDIC cells with sine/cosine quadrant mapping at the end
module pdt_cordic_chain import pdt_pkg::*; #(
  parameter int unsigned STAGES = DefCordicStages
) (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      feed_i,
  input  logic [31:0]               angle_i,
  output logic                      done_o,
  output logic signed [CordicW-1:0] cos_o,
  output logic signed [CordicW-1:0] sin_o
);

  cordic_t link [STAGES+1];
  cordic_t tail;

  assign link[0] = '{valid: feed_i, quad: angle_i[31:30], x: CordicGain, y: '0,
                     z: $signed({3'b000, angle_i[29:0]})};

  for (genvar g = 0; g < STAGES; g++) begin : g_cell
    pdt_cordic_cell #(.STAGE(g)) u_cell (
      .clk_i  (clk_i),
      .rst_ni (rst_ni),
      .cell_i (link[g]),
      .cell_o (link[g+1])
    );
  end

  assign tail   = link[STAGES];
  assign done_o = tail.valid;

  always_comb begin
    case (tail.quad)
      2'd0: begin
        cos_o = tail.x;
        sin_o = tail.y;
      end
      2'd1: begin
        cos_o = -tail.y;
        sin_o = tail.x;
      end
      2'd2: begin
        cos_o = -tail.x;
        sin_o = -tail.y;
      end
      default: begin
        cos_o = tail.y;
        sin_o = -tail.x;
      end
    endcase
  end

endmodule

>>> rtl/pendulum_trajectory_generator.sv
// Top level of the small-angle pendulum trajectory generator
// Usage: configure length, amplitude, omega, phase step and sample count
// over the APB port while idle, then send one request per sample on the
// input channel (restart_i clears phase and index first). Each request
// yields one result: index, angle, rate, bob position and velocity, and a
// last-sample flag; after the last sample phase and index return to zero.
// Each request is worked through two passes of the one row of CORDIC cells,
// four multiply steps and the result load. One request is taken at a time;
// the next is accepted as soon as the result is loaded into the output
// register, so a new request is not taken before the last one is through.
// Reset clears phase, index, config registers to their defaults and
// all valid flags. A stalled receiver holds the result stable; a new
// request may be worked on meanwhile and waits to load until it is taken.
module pendulum_trajectory_generator import pdt_pkg::*; #(
  parameter int unsigned CORDIC_STAGES = DefCordicStages,
  parameter int unsigned PHASE_BITS    = DefPhaseBits
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [4:0]         paddr,
  input  logic [31:0]        pwdata,
  output logic [31:0]        prdata,
  output logic               pready,
  input  logic               in_valid_i,
  output logic               in_ready_o,
  input  logic               restart_i,
  output logic               out_valid_o,
  input  logic               out_ready_i,
  output logic [19:0]        sample_index_o,
  output logic signed [17:0] swing_angle_o,
  output logic signed [23:0] angular_rate_o,
  output logic signed [19:0] x_position_o,
  output logic signed [19:0] y_position_o,
  output logic signed [19:0] x_velocity_o,
  output logic signed [19:0] y_velocity_o,
  output logic               last_sample_o
);

  localparam logic [31:0] PhaseMask = ~((32'd1 << (32 - PHASE_BITS)) - 32'd1);

  logic [17:0]        len_q;
  logic signed [17:0] amp_q;
  logic [23:0]        omega_q;
  logic [31:0]        step_q;
  logic [20:0]        count_q;
  logic [2:0]         reg_idx;
  logic               cfg_wr;

  logic [31:0] phase_q;
  logic [19:0] ctr_q;

  state_e state_q, state_d;

  logic                      feed;
  logic [31:0]               feed_angle;
  logic                      ch_done;
  logic signed [CordicW-1:0] ch_cos, ch_sin;

  logic signed [CordicW-1:0] c_q, s_q;
  logic [19:0]               idx_q;
  logic                      last_q;
  logic signed [17:0]        theta_q;
  logic signed [27:0]        t1_q;
  logic signed [23:0]        rate_q;
  logic signed [19:0]        px_q, py_q, vx_q, vy_q;
  logic signed [28:0]        t2_q;

  logic                      in_acc;
  logic                      load_out;
  logic [31:0]               phase_eff;
  logic [19:0]               idx_eff;
  logic [19:0]               lim;
  logic                      last_eff;

  logic signed [50:0] th_prod;
  logic signed [42:0] t1_prod;
  logic signed [60:0] rate_prod;
  logic signed [49:0] bin_prod;
  logic signed [51:0] px_prod, py_prod;
  logic signed [42:0] t2_prod;
  logic signed [61:0] vx_prod, vy_prod;
  logic signed [18:0] len_s;

  // APB
  assign pready  = 1'b1;
  assign reg_idx = paddr[4:2];
  assign cfg_wr  = psel && penable && pwrite;

  always_comb begin
    case (reg_idx)
      RegLength: prdata = {14'd0, len_q};
      RegAmp:    prdata = {14'd0, amp_q};
      RegOmega:  prdata = {8'd0, omega_q};
      RegStep:   prdata = step_q;
      RegCount:  prdata = {11'd0, count_q};
      default:   prdata = '0;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      len_q   <= 18'd1024;
      amp_q   <= '0;
      omega_q <= '0;
      step_q  <= '0;
      count_q <= 21'd1;
    end else if (cfg_wr) begin
      case (reg_idx)
        RegLength: len_q   <= pwdata[17:0];
        RegAmp:    amp_q   <= $signed(pwdata[17:0]);
        RegOmega:  omega_q <= pwdata[23:0];
        RegStep:   step_q  <= pwdata;
        RegCount:  count_q <= pwdata[20:0];
        default:   ;
      endcase
    end
  end

  // request and sample bookkeeping
  assign in_ready_o = (state_q == ST_IDLE);
  assign in_acc     = in_valid_i && in_ready_o;
  assign phase_eff  = restart_i ? '0 : phase_q;
  assign idx_eff    = restart_i ? '0 : ctr_q;

  always_comb begin
    if (count_q == '0) begin
      lim = '0;
    end else if (count_q > 21'h100000) begin
      lim = 20'hFFFFF;
    end else begin
      lim = 20'(count_q - 21'd1);
    end
  end

  assign last_eff = (idx_eff == lim);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= '0;
      ctr_q   <= '0;
    end else if (in_acc) begin
      if (last_eff) begin
        phase_q <= '0;
        ctr_q   <= '0;
      end else begin
        phase_q <= phase_eff + step_q;
        ctr_q   <= idx_eff + 20'd1;
      end
    end
  end

  // sequencer
  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE:  if (in_valid_i) state_d = ST_PASS1;
      ST_PASS1: if (ch_done) state_d = ST_MUL1;
      ST_MUL1:  state_d = ST_MUL2;
      ST_MUL2:  state_d = ST_PASS2;
      ST_PASS2: if (ch_done) state_d = ST_MUL3;
      ST_MUL3:  state_d = ST_MUL4;
      ST_MUL4:  state_d = ST_DONE;
      ST_DONE:  if (!out_valid_o || out_ready_i) state_d = ST_IDLE;
      default:  state_d = ST_IDLE;
    endcase
  end

  always_comb begin
    feed       = 1'b0;
    feed_angle = phase_eff & PhaseMask;
    load_out   = 1'b0;
    case (state_q)
      ST_IDLE: feed = in_acc;
      ST_MUL2: begin
        feed       = 1'b1;
        feed_angle = bin_prod[47:16];
      end
      ST_DONE: load_out = !out_valid_o || out_ready_i;
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  pdt_cordic_chain #(.STAGES(CORDIC_STAGES)) u_chain (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .feed_i  (feed),
    .angle_i (feed_angle),
    .done_o  (ch_done),
    .cos_o   (ch_cos),
    .sin_o   (ch_sin)
  );

  // multiply steps
  assign len_s     = $signed({1'b0, len_q});
  assign th_prod   = amp_q * c_q;
  assign t1_prod   = amp_q * $signed({1'b0, omega_q});
  assign rate_prod = t1_q * s_q;
  assign bin_prod  = theta_q * RadToBinang;
  assign px_prod   = len_s * s_q;
  assign py_prod   = len_s * c_q;
  assign t2_prod   = len_s * rate_q;
  assign vx_prod   = t2_q * c_q;
  assign vy_prod   = t2_q * s_q;

  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      idx_q  <= idx_eff;
      last_q <= last_eff;
    end
    if (ch_done) begin
      c_q <= ch_cos;
      s_q <= ch_sin;
    end
    case (state_q)
      ST_MUL1: begin
        theta_q <= 18'(sat(round_shift(64'(th_prod), 30), 18));
        t1_q    <= 28'(round_shift(64'(t1_prod), 16));
      end
      ST_MUL2: rate_q <= 24'(sat(-round_shift(64'(rate_prod), 30), 24));
      ST_MUL3: begin
        px_q <= 20'(sat(round_shift(64'(px_prod), 30), 20));
        py_q <= 20'(sat(-round_shift(64'(py_prod), 30), 20));
        t2_q <= 29'(round_shift(64'(t2_prod), 15));
      end
      ST_MUL4: begin
        vx_q <= 20'(sat(round_shift(64'(vx_prod), 30), 20));
        vy_q <= 20'(sat(round_shift(64'(vy_prod), 30), 20));
      end
      default: ;
    endcase
  end

  // output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_o <= 1'b0;
    end else if (load_out) begin
      out_valid_o <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_o <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load_out) begin
      sample_index_o <= idx_q;
      swing_angle_o  <= theta_q;
      angular_rate_o <= rate_q;
      x_position_o   <= px_q;
      y_position_o   <= py_q;
      x_velocity_o   <= vx_q;
      y_velocity_o   <= vy_q;
      last_sample_o  <= last_q;
    end
  end

endmodule

>>> rtl/pdt_checker.sv
// Port-level checker for the pendulum trajectory generator, with its bind
`include "pendulum_trajectory_generator_macros.svh"

module pdt_checker (
  input logic               clk_i,
  input logic               rst_ni,
  input logic               in_valid_i,
  input logic               in_ready_o,
  input logic               out_valid_o,
  input logic               out_ready_i,
  input logic [19:0]        sample_index_o,
  input logic signed [17:0] swing_angle_o
);

  `PDT_ASSERT_NEXT(a_out_hold, out_valid_o && !out_ready_i, out_valid_o)
  `PDT_ASSERT_NEXT(a_out_stable, out_valid_o && !out_ready_i, $stable(sample_index_o) && $stable(swing_angle_o))
  `PDT_ASSERT_NEXT(a_busy_after_req, in_valid_i && in_ready_o, !in_ready_o)
  `PDT_ASSERT_NOW(a_idle_on_result, $rose(out_valid_o), in_ready_o)

endmodule

bind pendulum_trajectory_generator pdt_checker u_pdt_checker (.*);

>>> verif/pendulum_trajectory_generator_checker.sv
// Checker for the pendulum trajectory generator: tracks config, predicts and compares samples
module pendulum_trajectory_generator_checker import pdt_pkg::*; (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [4:0]         paddr,
  input  logic [31:0]        pwdata,
  input  logic               pready,
  input  logic               in_valid_i,
  input  logic               in_ready_o,
  input  logic               restart_i,
  input  logic               out_valid_o,
  input  logic               out_ready_i,
  input  logic [19:0]        sample_index_o,
  input  logic signed [17:0] swing_angle_o,
  input  logic signed [23:0] angular_rate_o,
  input  logic signed [19:0] x_position_o,
  input  logic signed [19:0] y_position_o,
  input  logic signed [19:0] x_velocity_o,
  input  logic signed [19:0] y_velocity_o,
  input  logic               last_sample_o,
  output int                 fail_count_o,
  output int                 samples_due_o
);
  timeunit 1ns;
  timeprecision 1ps;

  typedef struct packed {
    logic [19:0]        index;
    logic signed [17:0] angle;
    logic signed [23:0] rate;
    logic signed [19:0] xpos;
    logic signed [19:0] ypos;
    logic signed [19:0] xvel;
    logic signed [19:0] yvel;
    logic               last;
  } sample_t;

  localparam longint ArcTurn [16] = '{
    536870912, 316933406, 167458907, 85004756, 42667331, 21354465,
    10679838, 5340245, 2670163, 1335087, 667544, 333772,
    166886, 83443, 41722, 20861
  };

  logic [17:0]        length_q;
  logic signed [17:0] amp_q;
  logic [23:0]        omega_q;
  logic [31:0]        step_q;
  logic [20:0]        count_q;
  logic [31:0]        phase_q;
  logic [19:0]        index_q;
  sample_t            due_q[$];

  function automatic longint rnd(input longint v, input int s);
    return (v + (64'sd1 <<< (s - 1))) >>> s;
  endfunction

  function automatic longint clip(input longint v, input int w);
    longint hi;
    hi = (64'sd1 <<< (w - 1)) - 1;
    return v > hi ? hi : (v < -hi - 1 ? -hi - 1 : v);
  endfunction

  task automatic rotate(input logic [31:0] ang, output longint c, output longint s);
    longint x, y, z, dx, dy;
    x = 652032874;
    y = 0;
    z = longint'(ang[29:0]);
    for (int i = 0; i < 16; i++) begin
      dx = y >>> i;
      dy = x >>> i;
      if (z >= 0) begin
        x -= dx; y += dy; z -= ArcTurn[i];
      end else begin
        x += dx; y -= dy; z += ArcTurn[i];
      end
    end
    case (ang[31:30])
      2'd0: begin c = x;  s = y;  end
      2'd1: begin c = -y; s = x;  end
      2'd2: begin c = -x; s = -y; end
      default: begin c = y; s = -x; end
    endcase
  endtask

  task automatic predict_sample(input logic restart);
    longint c1, s1, c2, s2, theta, rate, t, len;
    logic signed [63:0] prod;
    logic [20:0] lim;
    sample_t e;
    if (restart) begin
      phase_q = '0;
      index_q = '0;
    end
    rotate(phase_q, c1, s1);
    theta = clip(rnd(longint'(amp_q) * c1, 30), 18);
    t = rnd(longint'(amp_q) * longint'(omega_q), 16);
    rate = clip(-rnd(t * s1, 30), 24);
    prod = theta * 64'sd1367130551;
    rotate(prod[47:16], c2, s2);
    len = longint'(length_q);
    t = rnd(len * rate, 15);
    lim = count_q == 0 ? 21'd1 : (count_q > 21'h100000 ? 21'h100000 : count_q);
    e.index = index_q;
    e.angle = theta[17:0];
    e.rate  = rate[23:0];
    e.xpos  = 20'(clip(rnd(len * s2, 30), 20));
    e.ypos  = 20'(clip(-rnd(len * c2, 30), 20));
    e.xvel  = 20'(clip(rnd(t * c2, 30), 20));
    e.yvel  = 20'(clip(rnd(t * s2, 30), 20));
    e.last  = ({1'b0, index_q} == lim - 21'd1);
    due_q.push_back(e);
    if (e.last) begin
      phase_q = '0;
      index_q = '0;
    end else begin
      phase_q = phase_q + step_q;
      index_q = index_q + 20'd1;
    end
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    sample_t e, a;
    if (!rst_ni) begin
      length_q = 18'd1024;
      amp_q = '0;
      omega_q = '0;
      step_q = '0;
      count_q = 21'd1;
      phase_q = '0;
      index_q = '0;
      due_q.delete();
      fail_count_o = 0;
      samples_due_o = 0;
    end else begin
      if (psel && penable && pwrite && pready) begin
        case (paddr[4:2])
          RegLength: length_q = pwdata[17:0];
          RegAmp:    amp_q = pwdata[17:0];
          RegOmega:  omega_q = pwdata[23:0];
          RegStep:   step_q = pwdata;
          RegCount:  count_q = pwdata[20:0];
          default: ;
        endcase
      end
      if (in_valid_i && in_ready_o) predict_sample(restart_i);
      if (out_valid_o && out_ready_i) begin
        a = '{sample_index_o, swing_angle_o, angular_rate_o, x_position_o, y_position_o,
              x_velocity_o, y_velocity_o, last_sample_o};
        if (due_q.size() == 0) begin
          fail_count_o++;
          if (fail_count_o <= 10) $display("unexpected sample %p", a);
        end else begin
          e = due_q.pop_front();
          if (a !== e) begin
            fail_count_o++;
            if (fail_count_o <= 10) $display("sample mismatch exp %p got %p", e, a);
          end
        end
      end
      samples_due_o = due_q.size();
    end
  end

endmodule

>>> verif/tb_pendulum_trajectory_generator.sv
// Testbench top for the pendulum trajectory generator: stimulus, config and verdict
module tb_pendulum_trajectory_generator import pdt_pkg::*;;
  timeunit 1ns;
  timeprecision 1ps;

  logic               clk_i = 1'b0;
  logic               rst_ni = 1'b0;
  logic               psel = 1'b0, penable = 1'b0, pwrite = 1'b0;
  logic [4:0]         paddr = '0;
  logic [31:0]        pwdata = '0;
  logic [31:0]        prdata;
  logic               pready;
  logic               in_valid_i = 1'b0, restart_i = 1'b0, out_ready_i = 1'b0;
  logic               in_ready_o, out_valid_o, last_sample_o;
  logic [19:0]        sample_index_o;
  logic signed [17:0] swing_angle_o;
  logic signed [23:0] angular_rate_o;
  logic signed [19:0] x_position_o, y_position_o, x_velocity_o, y_velocity_o;
  int                 fail_count, samples_due;
  int                 stall_mode = 0;

  always begin
    #4 clk_i = 1'b1;
    #4 clk_i = 1'b0;
  end

  pendulum_trajectory_generator dut (.*);

  pendulum_trajectory_generator_checker checker_i (
    .*, .fail_count_o(fail_count), .samples_due_o(samples_due)
  );

  task automatic reg_write(input logic [2:0] idx, input logic [31:0] val);
    @(posedge clk_i);
    psel <= 1'b1; penable <= 1'b0; pwrite <= 1'b1;
    paddr <= {idx, 2'b00}; pwdata <= val;
    @(posedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    psel <= 1'b0; penable <= 1'b0; pwrite <= 1'b0;
  endtask

  task automatic settle();
    @(posedge clk_i);
    while (samples_due != 0) @(posedge clk_i);
    repeat (50) @(posedge clk_i);
  endtask

  task automatic configure(input logic [17:0] len, input logic [17:0] amp,
                           input logic [23:0] omega, input logic [31:0] step,
                           input logic [20:0] count);
    settle();
    reg_write(RegLength, {14'd0, len});
    reg_write(RegAmp, {14'd0, amp});
    reg_write(RegOmega, {8'd0, omega});
    reg_write(RegStep, step);
    reg_write(RegCount, {11'd0, count});
  endtask

  task automatic send_requests(input int n, input int restart_pct);
    int burst;
    while (n > 0) begin
      burst = $urandom_range(1, 12);
      while (burst > 0 && n > 0) begin
        in_valid_i <= 1'b1;
        restart_i <= ($urandom_range(0, 99) < restart_pct);
        do @(posedge clk_i); while (!in_ready_o);
        burst--;
        n--;
      end
      if ($urandom_range(0, 3) != 0) begin
        in_valid_i <= 1'b0;
        repeat ($urandom_range(1, 60)) @(posedge clk_i);
      end
    end
    in_valid_i <= 1'b0;
  endtask

  always @(posedge clk_i) begin
    if ($urandom_range(0, 199) == 0) stall_mode <= $urandom_range(0, 2);
    case (stall_mode)
      0: out_ready_i <= 1'b1;
      1: out_ready_i <= 1'($urandom_range(0, 1));
      default: out_ready_i <= ($urandom_range(0, 7) == 0);
    endcase
  end

  initial begin
    #50ms;
    $display("TEST FAILED");
    $finish;
  end

  initial begin
    logic [20:0] cnt;
    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;
    send_requests(2, 0);
    configure(18'h3FFFF, 18'h20000, 24'hFFFFFF, 32'h40000000, 21'd5);
    send_requests(6, 0);
    configure(18'h3FFFF, 18'h1FFFF, 24'hFFFFFF, 32'hFFFFFFFF, 21'd0);
    send_requests(3, 50);
    configure(18'd0, 18'h1FFFF, 24'd0, 32'h2000_0000, 21'h1FFFFF);
    send_requests(4, 0);
    configure(18'd1, 18'h0C000, 24'h1A000, 32'h0123_4567, 21'h100000);
    send_requests(3, 0);
    configure(18'd2048, 18'h08000, 24'h32000, 32'h0800_0000, 21'd2);
    send_requests(3, 0);
    for (int ph = 0; ph < 14; ph++) begin
      case ($urandom_range(0, 9))
        0: cnt = 21'd0;
        1: cnt = 21'($urandom_range(21'h100000, 21'h1FFFFF));
        default: cnt = 21'($urandom_range(1, 64));
      endcase
      configure(($urandom_range(0, 9) == 0) ? 18'h3FFFF : 18'($urandom),
                18'($urandom),
                ($urandom_range(0, 9) == 0) ? 24'hFFFFFF : 24'($urandom_range(0, 24'h60000)),
                $urandom, cnt);
      send_requests(90, $urandom_range(0, 15));
    end
    settle();
    if (fail_count == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule

>>> files.f
+incdir+rtl
rtl/pdt_pkg.sv
rtl/pdt_cordic_cell.sv
rtl/pdt_cordic_chain.sv
rtl/pendulum_trajectory_generator.sv
rtl/pdt_checker.sv
verif/pendulum_trajectory_generator_checker.sv
verif/tb_pendulum_trajectory_generator.sv
